// ===== rtl/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg: shared types, constants and fixed-point helpers
// Q16.16 widths, easing codes, register indexes and saturation helpers used
// by the front stage, the queue, the dividers and the back pipeline.
// ----------------------------------------------------------------------------
package rme_pkg;

    // Data format
    localparam int DW       = 32;          // data width
    localparam int F        = 16;          // fraction bits
    localparam int MW       = DW + 1;      // magnitude of a difference
    localparam int RW       = DW + 2;      // divider remainder
    localparam int SW       = DW + 4;      // headroom for small sums
    localparam int PW       = 2 * DW;      // product of two magnitudes
    localparam int ADDR_W   = 5;
    localparam int OUT_TW   = ((DW + 1 + 7) / 8) * 8;

    // Pipeline lengths
    localparam int DIV_LAT  = DW + 1;
    localparam int BACK_LAT = 2 * DIV_LAT + 9;

    localparam logic signed [DW-1:0] ONE_FX = DW'(64'd1 << F);
    localparam logic signed [DW-1:0] DMAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN   = {1'b1, {(DW-1){1'b0}}};

    // Slingshot constants: KH = k/2 rounded from Q0.32, K2 = 1 + KH
    localparam logic [63:0] KH_Q32 = 64'd2750446389;
    localparam logic [63:0] KH_W   = (KH_Q32 + (64'd1 << (31 - F))) >> (32 - F);
    localparam logic signed [DW-1:0] KH_FX  = DW'(KH_W);
    localparam logic [DW-1:0]        K2_MAG = DW'(KH_W + (64'd1 << F));

    // Easing codes
    localparam logic [2:0] EASE_LIN    = 3'd0;
    localparam logic [2:0] EASE_IN     = 3'd1;
    localparam logic [2:0] EASE_OUT    = 3'd2;
    localparam logic [2:0] EASE_SMOOTH = 3'd3;
    localparam logic [2:0] EASE_SLING  = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_IN_START  = 3'd0;
    localparam logic [2:0] REG_IN_END    = 3'd1;
    localparam logic [2:0] REG_OUT_START = 3'd2;
    localparam logic [2:0] REG_OUT_END   = 3'd3;
    localparam logic [2:0] REG_CLAMP     = 3'd4;
    localparam logic [2:0] REG_EASE      = 3'd5;

    typedef struct packed {
        logic signed [DW-1:0] in_start;
        logic signed [DW-1:0] in_end;
        logic signed [DW-1:0] out_start;
        logic signed [DW-1:0] out_end;
        logic                 clamp_en;
        logic [2:0]           ease_mode;
    } cfg_t;

    typedef struct packed {
        logic [MW-1:0] num_mag;
        logic [MW-1:0] den_mag;
        logic          neg;
    } div_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_st_t;

    typedef struct packed {
        logic                 sat;
        logic signed [DW-1:0] val;
    } fx_res_t;

    // Sign-extend a data word into the headroom width
    function automatic logic signed [SW-1:0] ext_dw(input logic signed [DW-1:0] a);
        return SW'(a);
    endfunction

    // Saturate a wide sum to the data range
    function automatic fx_res_t sat_dw(input logic signed [SW-1:0] x);
        fx_res_t r;
        if (x > SW'(DMAX)) begin
            r.sat = 1'b1;
            r.val = DMAX;
        end else if (x < SW'(DMIN)) begin
            r.sat = 1'b1;
            r.val = DMIN;
        end else begin
            r.sat = 1'b0;
            r.val = x[DW-1:0];
        end
        return r;
    endfunction

    // Magnitude of a data word
    function automatic logic [DW-1:0] mag_dw(input logic signed [DW-1:0] a);
        logic [DW-1:0] u;
        u = a;
        return a[DW-1] ? (~u + 1'b1) : u;
    endfunction

    // Scale a magnitude product, saturate and apply the sign
    function automatic fx_res_t mul_fin(input logic [PW-1:0] p, input logic neg);
        logic [PW-1:0] q;
        logic [PW-1:0] cap;
        fx_res_t       r;
        q   = p >> F;
        cap = neg ? (PW'(1) << (DW - 1)) : ((PW'(1) << (DW - 1)) - PW'(1));
        if (q > cap) begin
            r.sat = 1'b1;
            q     = cap;
        end else begin
            r.sat = 1'b0;
        end
        r.val = neg ? (~q[DW-1:0] + 1'b1) : q[DW-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/rme_front.sv =====
// ----------------------------------------------------------------------------
// rme_front: input stage
// Accepts samples, forms the numerator and denominator of the fraction as
// magnitudes with a sign, and hands them to the queue.
// ----------------------------------------------------------------------------
module rme_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rme_pkg::cfg_t              cfg,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rme_pkg::DW-1:0]     s_tdata,     // [31:0] sample_value
    input  rme_pkg::fifo_st_t          q_st,
    output logic                       push,
    output rme_pkg::div_item_t         item
);
    import rme_pkg::*;

    logic                 fv_reg;
    div_item_t            item_reg;
    logic signed [DW-1:0] sample;
    logic signed [MW-1:0] num;
    logic signed [MW-1:0] den;
    div_item_t            item_next;

    // Hand over when the queue has room
    assign push     = fv_reg && !q_st.full;
    assign s_tready = !fv_reg || push;
    assign item     = item_reg;

    // Classify: signed differences split into magnitude and sign
    always_comb begin
        sample = s_tdata;
        num    = MW'(sample) - MW'(cfg.in_start);
        den    = MW'(cfg.in_end) - MW'(cfg.in_start);
        item_next.num_mag = num[MW-1] ? (~num + 1'b1) : num;
        item_next.den_mag = den[MW-1] ? (~den + 1'b1) : den;
        item_next.neg     = num[MW-1] ^ den[MW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            fv_reg <= 1'b1;
        end else if (push) begin
            fv_reg <= 1'b0;
        end
    end

    // Capture payload on each input transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/rme_fifo.sv =====
// ----------------------------------------------------------------------------
// rme_fifo: two-entry queue
// Decouples the input stage from the back pipeline so either can stall.
// ----------------------------------------------------------------------------
module rme_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rme_pkg::div_item_t   wr_item,
    input  logic                 pop,
    output rme_pkg::div_item_t   head,
    output rme_pkg::fifo_st_t    st
);
    import rme_pkg::*;

    div_item_t  mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign head     = mem_reg[rd_ptr_reg];
    assign st.full  = (cnt_reg == 2'd2);
    assign st.empty = (cnt_reg == 2'd0);

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/rme_div.sv =====
// ----------------------------------------------------------------------------
// rme_div: pipelined fixed-point divider
// Restoring division, one quotient bit per stage, giving the saturated
// signed quotient (num << F) / den truncated toward zero.
// ----------------------------------------------------------------------------
module rme_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [rme_pkg::MW-1:0]        num_mag,
    input  logic [rme_pkg::MW-1:0]        den_mag,
    input  logic                          neg,
    output logic signed [rme_pkg::DW-1:0] quo,
    output logic                          quo_sat
);
    import rme_pkg::*;

    localparam int QB = DW - 1;
    localparam int SH = DW - 1 - F;

    logic [RW-1:0] rem_reg  [0:QB];
    logic [QB-1:0] bits_reg [0:QB];
    logic [QB-1:0] q_reg    [0:QB];
    logic [MW-1:0] den_reg  [0:QB];
    logic          neg_reg  [0:QB];
    logic          sat_reg  [0:QB];
    logic          top_reg  [0:QB];
    logic [RW-1:0] rem0;
    logic [RW-1:0] den0;
    logic          top0;
    logic          sat_out;

    // Load: take out the 2^(DW-1) quotient bit; twice that or more saturates
    assign rem0 = RW'(num_mag >> SH);
    assign den0 = RW'(den_mag);
    assign top0 = (rem0 >= den0);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= top0 ? (rem0 - den0) : rem0;
            bits_reg[0] <= {num_mag[SH-1:0], {F{1'b0}}};
            q_reg[0]    <= '0;
            den_reg[0]  <= den_mag;
            neg_reg[0]  <= neg;
            sat_reg[0]  <= (rem0 >= (den0 << 1));
            top_reg[0]  <= top0;
        end
    end

    // One quotient bit per stage
    for (genvar i = 1; i <= QB; i++) begin : g_step
        logic [RW-1:0] trial;
        logic          ge;
        always_comb begin
            trial = {rem_reg[i-1][RW-2:0], bits_reg[i-1][QB-1]};
            ge    = (trial >= RW'(den_reg[i-1]));
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? (trial - RW'(den_reg[i-1])) : trial;
                bits_reg[i] <= {bits_reg[i-1][QB-2:0], 1'b0};
                q_reg[i]    <= {q_reg[i-1][QB-2:0], ge};
                den_reg[i]  <= den_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                sat_reg[i]  <= sat_reg[i-1];
                top_reg[i]  <= top_reg[i-1];
            end
        end
    end

    // A negative quotient of exactly 2^(DW-1) still fits
    assign sat_out = sat_reg[QB] ||
                     (top_reg[QB] && !(neg_reg[QB] && q_reg[QB] == '0));

    // Apply sign and saturation
    always_ff @(posedge aclk) begin
        if (en) begin
            quo_sat <= sat_out;
            if (sat_out) begin
                quo <= neg_reg[QB] ? DMIN : DMAX;
            end else if (neg_reg[QB]) begin
                quo <= ~{top_reg[QB], q_reg[QB]} + 1'b1;
            end else begin
                quo <= {top_reg[QB], q_reg[QB]};
            end
        end
    end

endmodule

// ===== rtl/rme_back.sv =====
// ----------------------------------------------------------------------------
// rme_back: execution pipeline
// Fraction division, clamp, easing curve, slingshot division and the final
// interpolation into the target range, with the result register.
// ----------------------------------------------------------------------------
module rme_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rme_pkg::cfg_t                cfg,
    input  rme_pkg::div_item_t           head,
    input  rme_pkg::fifo_st_t            q_st,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rme_pkg::OUT_TW-1:0]   m_tdata    // [31:0] mapped_value, [32] saturated
);
    import rme_pkg::*;

    localparam int TW = DW + MW + 2;

    logic en;
    logic vld_reg [0:BACK_LAT-1];
    logic is_in, is_out, is_smooth, is_sling, is_lin;

    // Fraction divider
    logic signed [DW-1:0] frac_q;
    logic                 frac_sat;

    // Stage 1
    logic signed [DW-1:0] x_c;
    logic                 sat0;
    fx_res_t              one_minus;
    logic signed [DW-1:0] pre;
    logic signed [DW-1:0] x1_reg;
    logic [DW-1:0]        a1_mag_reg;
    logic                 sat1_reg;

    // Stage 2
    logic [PW-1:0]        sq2_reg;
    logic [PW-1:0]        kx2_reg;
    logic signed [DW-1:0] x2_reg;
    logic                 sat2_reg;

    // Stage 3
    fx_res_t              s_fin;
    fx_res_t              t_fin;
    logic signed [DW-1:0] s3_reg;
    logic signed [DW-1:0] t3_reg;
    logic signed [DW-1:0] x3_reg;
    logic                 sat3_reg;

    // Stage 4
    logic [PW-1:0]        pc4_reg;
    logic signed [DW-1:0] s4_reg;
    logic signed [DW-1:0] t4_reg;
    logic signed [DW-1:0] x4_reg;
    logic                 sat4_reg;

    // Stage 5
    fx_res_t              c_fin;
    logic signed [DW-1:0] c5_reg;
    logic signed [DW-1:0] s5_reg;
    logic signed [DW-1:0] t5_reg;
    logic signed [DW-1:0] x5_reg;
    logic                 sat5_reg;

    // Stage 6
    fx_res_t              r2, r3a, r3b, r3, r4;
    logic signed [DW-1:0] e_next;
    logic                 esat_next;
    logic signed [DW-1:0] e6_reg;
    logic                 e6_sat_reg;
    logic [MW-1:0]        d6_num_reg;
    logic [MW-1:0]        d6_den_reg;
    logic                 d6_neg_reg;

    // Slingshot divider and delay line
    logic signed [DW-1:0] sl_q;
    logic                 sl_sat;
    logic signed [DW-1:0] ed_val_reg [0:DIV_LAT-1];
    logic                 ed_sat_reg [0:DIV_LAT-1];

    // Stage 7
    logic signed [DW-1:0] f_sel;
    logic signed [MW-1:0] dd;
    logic [DW-1:0]        f7_mag_reg;
    logic [MW-1:0]        dd7_mag_reg;
    logic                 neg7_reg;
    logic                 sat7_reg;

    // Stage 8
    logic [DW+MW-1:0]     prod8_reg;
    logic                 neg8_reg;
    logic                 sat8_reg;

    // Stage 9
    logic [DW+MW-1:0]     q9;
    logic signed [TW-2:0] res9;
    logic signed [TW-1:0] sum9;
    logic signed [DW:0]   mid_sum;
    logic signed [DW:0]   mid_adj;
    logic                 empty_rng;
    logic signed [DW-1:0] val_next;
    logic                 sat_next;
    logic signed [DW-1:0] out_val_reg;
    logic                 out_sat_reg;

    // Whole pipeline moves unless the result register is held
    assign en       = !m_tvalid || m_tready;
    assign pop      = en && !q_st.empty;
    assign m_tvalid = vld_reg[BACK_LAT-1];
    assign m_tdata  = {{(OUT_TW-DW-1){1'b0}}, out_sat_reg, out_val_reg};

    assign is_in     = (cfg.ease_mode == EASE_IN);
    assign is_out    = (cfg.ease_mode == EASE_OUT);
    assign is_smooth = (cfg.ease_mode == EASE_SMOOTH);
    assign is_sling  = (cfg.ease_mode == EASE_SLING);
    assign is_lin    = !(is_in || is_out || is_smooth || is_sling);

    // Track valid slots
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BACK_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= pop;
            for (int i = 1; i < BACK_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    rme_div u_div_frac (
        .aclk    (aclk),
        .en      (en),
        .num_mag (head.num_mag),
        .den_mag (head.den_mag),
        .neg     (head.neg),
        .quo     (frac_q),
        .quo_sat (frac_sat)
    );

    // Clamp, then pick the operand to square
    always_comb begin
        if (cfg.clamp_en && frac_q < 0) begin
            x_c = '0;
        end else if (cfg.clamp_en && frac_q > ONE_FX) begin
            x_c = ONE_FX;
        end else begin
            x_c = frac_q;
        end
        sat0      = !cfg.clamp_en && frac_sat;
        one_minus = sat_dw(ext_dw(ONE_FX) - ext_dw(x_c));
        pre       = is_out ? one_minus.val : x_c;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg     <= x_c;
            a1_mag_reg <= mag_dw(pre);
            sat1_reg   <= sat0 || (is_out && one_minus.sat);
        end
    end

    // Square and slingshot numerator products
    always_ff @(posedge aclk) begin
        if (en) begin
            sq2_reg  <= PW'(a1_mag_reg) * PW'(a1_mag_reg);
            kx2_reg  <= PW'(K2_MAG) * PW'(mag_dw(x1_reg));
            x2_reg   <= x1_reg;
            sat2_reg <= sat1_reg;
        end
    end

    // Scale products
    always_comb begin
        s_fin = mul_fin(sq2_reg, 1'b0);
        t_fin = mul_fin(kx2_reg, x2_reg[DW-1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg   <= s_fin.val;
            t3_reg   <= t_fin.val;
            x3_reg   <= x2_reg;
            sat3_reg <= sat2_reg || (!is_lin && s_fin.sat) || (is_sling && t_fin.sat);
        end
    end

    // Cube product
    always_ff @(posedge aclk) begin
        if (en) begin
            pc4_reg  <= PW'(mag_dw(s3_reg)) * PW'(mag_dw(x3_reg));
            s4_reg   <= s3_reg;
            t4_reg   <= t3_reg;
            x4_reg   <= x3_reg;
            sat4_reg <= sat3_reg;
        end
    end

    assign c_fin = mul_fin(pc4_reg, x4_reg[DW-1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            c5_reg   <= c_fin.val;
            s5_reg   <= s4_reg;
            t5_reg   <= t4_reg;
            x5_reg   <= x4_reg;
            sat5_reg <= sat4_reg || (is_smooth && c_fin.sat);
        end
    end

    // Combine terms of each curve
    always_comb begin
        r2  = sat_dw(ext_dw(ONE_FX) - ext_dw(s5_reg));
        r3a = sat_dw((ext_dw(s5_reg) <<< 1) + ext_dw(s5_reg));
        r3b = sat_dw(ext_dw(c5_reg) <<< 1);
        r3  = sat_dw(ext_dw(r3a.val) - ext_dw(r3b.val));
        r4  = sat_dw(ext_dw(s5_reg) + ext_dw(KH_FX));
        if (is_in) begin
            e_next    = s5_reg;
            esat_next = 1'b0;
        end else if (is_out) begin
            e_next    = r2.val;
            esat_next = r2.sat;
        end else if (is_smooth) begin
            e_next    = r3.val;
            esat_next = r3a.sat || r3b.sat || r3.sat;
        end else if (is_sling) begin
            e_next    = x5_reg;
            esat_next = r4.sat;
        end else begin
            e_next    = x5_reg;
            esat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e6_reg     <= e_next;
            e6_sat_reg <= sat5_reg || esat_next;
            d6_num_reg <= MW'(mag_dw(t5_reg));
            d6_den_reg <= MW'(mag_dw(r4.val));
            d6_neg_reg <= t5_reg[DW-1];
        end
    end

    rme_div u_div_sling (
        .aclk    (aclk),
        .en      (en),
        .num_mag (d6_num_reg),
        .den_mag (d6_den_reg),
        .neg     (d6_neg_reg),
        .quo     (sl_q),
        .quo_sat (sl_sat)
    );

    // Delay the other curves alongside the slingshot divider
    always_ff @(posedge aclk) begin
        if (en) begin
            ed_val_reg[0] <= e6_reg;
            ed_sat_reg[0] <= e6_sat_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                ed_val_reg[i] <= ed_val_reg[i-1];
                ed_sat_reg[i] <= ed_sat_reg[i-1];
            end
        end
    end

    // Select eased fraction, form the target span
    always_comb begin
        f_sel = is_sling ? sl_q : ed_val_reg[DIV_LAT-1];
        dd    = MW'(cfg.out_end) - MW'(cfg.out_start);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f7_mag_reg  <= mag_dw(f_sel);
            dd7_mag_reg <= dd[MW-1] ? (~dd + 1'b1) : dd;
            neg7_reg    <= f_sel[DW-1] ^ dd[MW-1];
            sat7_reg    <= ed_sat_reg[DIV_LAT-1] || (is_sling && sl_sat);
        end
    end

    // Interpolation product
    always_ff @(posedge aclk) begin
        if (en) begin
            prod8_reg <= (DW+MW)'(f7_mag_reg) * (DW+MW)'(dd7_mag_reg);
            neg8_reg  <= neg7_reg;
            sat8_reg  <= sat7_reg;
        end
    end

    // Offset, saturate, or return the midpoint for an empty source range
    always_comb begin
        q9        = prod8_reg >> F;
        res9      = neg8_reg ? -$signed({1'b0, q9}) : $signed({1'b0, q9});
        sum9      = TW'(res9) + TW'(cfg.out_start);
        mid_sum   = (DW+1)'(cfg.out_start) + (DW+1)'(cfg.out_end);
        mid_adj   = mid_sum + $signed({{DW{1'b0}}, mid_sum[DW]});
        empty_rng = (cfg.in_start == cfg.in_end);
        if (empty_rng) begin
            val_next = mid_adj[DW:1];
            sat_next = 1'b0;
        end else if (sum9 > TW'(DMAX)) begin
            val_next = DMAX;
            sat_next = 1'b1;
        end else if (sum9 < TW'(DMIN)) begin
            val_next = DMIN;
            sat_next = 1'b1;
        end else begin
            val_next = sum9[DW-1:0];
            sat_next = sat8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_val_reg <= val_next;
            out_sat_reg <= sat_next;
        end
    end

endmodule

// ===== rtl/range_map_with_easing.sv =====
// Path: input register, queue, then the 75-stage execution pipeline.
// Throughput: one item per cycle while the output is not held; both dividers
// retire one quotient bit per stage over 31 stages, so each stage takes a new
// item every cycle unless the output is held.
// Reset: synchronous, active low; clears valid state and queue, and loads the
// registers with in/out range 0 to 1.0, clamp off, identity curve.
// ----------------------------------------------------------------------------
// range_map_with_easing: top level
// Register file on the APB-style port, input stage, queue and execution
// pipeline for the Q16.16 range remap with easing.
// ----------------------------------------------------------------------------
module range_map_with_easing (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rme_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rme_pkg::DW-1:0]        s_tdata,   // [31:0] sample_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rme_pkg::OUT_TW-1:0]    m_tdata    // [31:0] mapped_value, [32] saturated
);
    import rme_pkg::*;

    cfg_t      cfg_reg;
    logic      wr_en;
    logic      push;
    logic      pop;
    div_item_t fr_item;
    div_item_t q_head;
    fifo_st_t  q_st;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_start  <= '0;
            cfg_reg.in_end    <= ONE_FX;
            cfg_reg.out_start <= '0;
            cfg_reg.out_end   <= ONE_FX;
            cfg_reg.clamp_en  <= 1'b0;
            cfg_reg.ease_mode <= EASE_LIN;
        end else if (wr_en) begin
            case (paddr[ADDR_W-1:2])
                REG_IN_START:  cfg_reg.in_start  <= pwdata;
                REG_IN_END:    cfg_reg.in_end    <= pwdata;
                REG_OUT_START: cfg_reg.out_start <= pwdata;
                REG_OUT_END:   cfg_reg.out_end   <= pwdata;
                REG_CLAMP:     cfg_reg.clamp_en  <= pwdata[0];
                REG_EASE:      cfg_reg.ease_mode <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_IN_START:  prdata = cfg_reg.in_start;
            REG_IN_END:    prdata = cfg_reg.in_end;
            REG_OUT_START: prdata = cfg_reg.out_start;
            REG_OUT_END:   prdata = cfg_reg.out_end;
            REG_CLAMP:     prdata = {31'd0, cfg_reg.clamp_en};
            REG_EASE:      prdata = {29'd0, cfg_reg.ease_mode};
            default:       prdata = '0;
        endcase
    end

    rme_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_st     (q_st),
        .push     (push),
        .item     (fr_item)
    );

    rme_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (fr_item),
        .pop     (pop),
        .head    (q_head),
        .st      (q_st)
    );

    rme_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (q_head),
        .q_st     (q_st),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // An empty source range never flags saturation
    a_empty_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cfg_reg.in_start == cfg_reg.in_end) |-> !m_tdata[DW])
        else $error("saturated set for empty source range");

    // Clamped identity stays inside the target range
    a_clamp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cfg_reg.clamp_en && cfg_reg.ease_mode == EASE_LIN) |->
        (($signed(m_tdata[DW-1:0]) >= cfg_reg.out_start &&
          $signed(m_tdata[DW-1:0]) <= cfg_reg.out_end) ||
         ($signed(m_tdata[DW-1:0]) <= cfg_reg.out_start &&
          $signed(m_tdata[DW-1:0]) >= cfg_reg.out_end)))
        else $error("clamped identity result outside target range");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule
